// ===== hw/rtl/strm_pkg.sv =====
// ----------------------------------------------------------------------------
// strm_pkg: shared definitions for the sparse table range-minimum core
// Field widths, status codes, item mode codes and parameter defaults.
// ----------------------------------------------------------------------------
package strm_pkg;

   localparam int MAX_ITEMS_DEF    = 1024;
   localparam int TABLE_LEVELS_DEF = 11;
   localparam int VALUE_BITS_DEF   = 32;

   // fixed item field widths
   localparam int SAMPLE_W = 32;
   localparam int RANGE_W  = 10;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_REJECT   = 2'd1,
      ST_BUILT    = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

endpackage

// ===== hw/rtl/sparse_table_range_min_core.sv =====
// ----------------------------------------------------------------------------
// sparse_table_range_min_core: sparse table range-minimum block
// Loads a set of signed Q16.16 values, builds a table of minimum positions
// over power-of-two spans with one shared compare unit, and answers
// inclusive range-minimum queries with two overlapping span lookups.
// ----------------------------------------------------------------------------
//
//  channel  dir   handshake            payload
//  -------  ----  -------------------  -------------------------------------------
//  req      in    req_valid/req_ready  mode, sample_value, last_sample, range_l/r
//  rsp      out   rsp_valid/rsp_ready  min_value, min_index, status, item_count
//
//  Steps: a plain load is written straight from idle. A query runs check, table
//  read, value read, compare and result. The build after the last load runs a
//  table read, value read and compare per table entry above level 0, plus
//  one level step per level; the single table read/value read/compare loop
//  serves queries too. Level 0 is written during the loads themselves.
//  Reset clears control state only; the stores need no clearing pass.
//  A stalled result holds in the output register; the core keeps taking
//  items meanwhile and only waits when a second result is ready to go out.
//
module sparse_table_range_min_core #(
   parameter int MAX_ITEMS    = strm_pkg::MAX_ITEMS_DEF,
   parameter int TABLE_LEVELS = strm_pkg::TABLE_LEVELS_DEF,
   parameter int VALUE_BITS   = strm_pkg::VALUE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_mode,
   input  logic signed [strm_pkg::SAMPLE_W-1:0]  req_sample_value,
   input  logic                                  req_last_sample,
   input  logic        [strm_pkg::RANGE_W-1:0]   req_range_left,
   input  logic        [strm_pkg::RANGE_W-1:0]   req_range_right,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [strm_pkg::SAMPLE_W-1:0]  rsp_min_value,
   output logic        [strm_pkg::RANGE_W-1:0]   rsp_min_index,
   output logic        [strm_pkg::STATUS_W-1:0]  rsp_status,
   output logic        [strm_pkg::COUNT_W-1:0]   rsp_item_count
);
   import strm_pkg::*;

   // index into the value store, element count, table level
   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int LVL_W = $clog2(TABLE_LEVELS);
   localparam int TA_W  = $clog2(TABLE_LEVELS * MAX_ITEMS);
   // working width for spans, lengths and range compares
   localparam int WW0   = (CNT_W > TABLE_LEVELS) ? CNT_W : TABLE_LEVELS;
   localparam int WW    = ((WW0 > RANGE_W + 1) ? WW0 : RANGE_W + 1) + 1;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_QCHK = 7'b0000010,   // validate query range, pick span level
      S_LVL  = 7'b0000100,   // start next build level or finish build
      S_TRD  = 7'b0001000,   // read two table entries
      S_VRD  = 7'b0010000,   // read the two values they point to
      S_CMP  = 7'b0100000,   // shared compare: build write or query result
      S_DONE = 7'b1000000    // hand result to the output register
   } state_type;

   // storage
   logic [VALUE_BITS-1:0] value_mem [MAX_ITEMS];
   logic [IDX_W-1:0]      tbl_mem   [TABLE_LEVELS * MAX_ITEMS];

   // control registers
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 ready_ff, ready_in;       // table built for this set
   logic                 rsp_valid_ff, rsp_valid_in;

   // working registers
   logic                 is_query_ff, is_query_in;
   logic [LVL_W-1:0]     rdlvl_ff, rdlvl_in;       // level the table reads use
   logic [IDX_W-1:0]     pos_a_ff, pos_a_in;
   logic [IDX_W-1:0]     pos_b_ff, pos_b_in;
   logic [RANGE_W-1:0]   q_left_ff, q_left_in;
   logic [RANGE_W-1:0]   q_right_ff, q_right_in;
   logic signed [SAMPLE_W-1:0] res_val_ff, res_val_in;
   logic [RANGE_W-1:0]   res_idx_ff, res_idx_in;
   status_type           res_stat_ff, res_stat_in;

   // output registers
   logic signed [SAMPLE_W-1:0] rsp_val_ff;
   logic [RANGE_W-1:0]   rsp_idx_ff;
   status_type           rsp_stat_ff;
   logic [COUNT_W-1:0]   rsp_cnt_ff;

   // memory read data
   logic [IDX_W-1:0]      tbl_a_ff, tbl_b_ff;
   logic [VALUE_BITS-1:0] val_a_ff, val_b_ff;

   // memory controls
   logic                  val_we, tbl_we, tbl_rd_en, val_rd_en;
   logic [IDX_W-1:0]      val_wa;
   logic [VALUE_BITS-1:0] val_wd;
   logic [TA_W-1:0]       tbl_wa, tbl_ra, tbl_rb;
   logic [IDX_W-1:0]      tbl_wd;

   // datapath temporaries
   logic [CNT_W-1:0]      base;
   logic                  drop;
   logic [WW-1:0]         len;
   logic [LVL_W-1:0]      qk;
   logic [LVL_W:0]        lvl_next;
   logic                  pick_a;
   logic [IDX_W-1:0]      pick_idx;
   logic signed [VALUE_BITS-1:0] pick_val;
   logic                  out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // shared compare unit, ties go to the lower index (first span)
   assign pick_a   = $signed(val_a_ff) <= $signed(val_b_ff);
   assign pick_idx = pick_a ? tbl_a_ff : tbl_b_ff;
   assign pick_val = pick_a ? $signed(val_a_ff) : $signed(val_b_ff);

   assign lvl_next = {1'b0, rdlvl_ff} + 1'b1;
   assign len      = WW'(q_right_ff) - WW'(q_left_ff) + WW'(1);
   assign tbl_ra   = TA_W'(rdlvl_ff) * TA_W'(MAX_ITEMS) + TA_W'(pos_a_ff);
   assign tbl_rb   = TA_W'(rdlvl_ff) * TA_W'(MAX_ITEMS) + TA_W'(pos_b_ff);

   // floor(log2(len)), capped at the top level
   always_comb begin
      qk = '0;
      for (int j = 0; j < TABLE_LEVELS; j++) begin
         if (len >= (WW'(1) << j)) begin
            qk = LVL_W'(j);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ready_in     = ready_ff;
      is_query_in  = is_query_ff;
      rdlvl_in     = rdlvl_ff;
      pos_a_in     = pos_a_ff;
      pos_b_in     = pos_b_ff;
      q_left_in    = q_left_ff;
      q_right_in   = q_right_ff;
      res_val_in   = res_val_ff;
      res_idx_in   = res_idx_ff;
      res_stat_in  = res_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      val_we       = 1'b0;
      val_wa       = '0;
      val_wd       = '0;
      tbl_we       = 1'b0;
      tbl_wa       = '0;
      tbl_wd       = '0;
      tbl_rd_en    = 1'b0;
      val_rd_en    = 1'b0;
      base         = ready_ff ? '0 : cnt_ff;
      drop         = (base == CNT_W'(MAX_ITEMS));

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_LOAD) begin
                  // first load after a build starts a new set
                  is_query_in = 1'b0;
                  ready_in    = 1'b0;
                  cnt_in      = base;
                  if (!drop) begin
                     val_we = 1'b1;
                     val_wa = IDX_W'(base);
                     val_wd = VALUE_BITS'(req_sample_value);
                     // level 0 of the table points at itself
                     tbl_we = 1'b1;
                     tbl_wa = TA_W'(base);
                     tbl_wd = IDX_W'(base);
                     cnt_in = base + 1'b1;
                  end
                  res_val_in  = '0;
                  res_idx_in  = '0;
                  res_stat_in = drop ? ST_OVERFLOW : ST_BUILT;
                  if (req_last_sample) begin
                     rdlvl_in = '0;
                     state_in = S_LVL;
                  end else if (drop) begin
                     state_in = S_DONE;
                  end
               end else begin
                  is_query_in = 1'b1;
                  q_left_in   = req_range_left;
                  q_right_in  = req_range_right;
                  state_in    = S_QCHK;
               end
            end
         end
         S_QCHK: begin
            if (!ready_ff || cnt_ff == '0 || q_left_ff > q_right_ff ||
                WW'(q_right_ff) >= WW'(cnt_ff)) begin
               res_val_in  = '0;
               res_idx_in  = '0;
               res_stat_in = ST_REJECT;
               state_in    = S_DONE;
            end else begin
               rdlvl_in = qk;
               pos_a_in = IDX_W'(q_left_ff);
               pos_b_in = IDX_W'(WW'(q_right_ff) + WW'(1) - (WW'(1) << qk));
               state_in = S_TRD;
            end
         end
         S_LVL: begin
            if (lvl_next < (LVL_W + 1)'(TABLE_LEVELS) &&
                (WW'(1) << lvl_next) <= WW'(cnt_ff)) begin
               pos_a_in = '0;
               pos_b_in = IDX_W'(WW'(1) << rdlvl_ff);
               state_in = S_TRD;
            end else begin
               ready_in = 1'b1;
               state_in = S_DONE;
            end
         end
         S_TRD: begin
            tbl_rd_en = 1'b1;
            state_in  = S_VRD;
         end
         S_VRD: begin
            val_rd_en = 1'b1;
            state_in  = S_CMP;
         end
         S_CMP: begin
            if (is_query_ff) begin
               res_val_in  = SAMPLE_W'(pick_val);
               res_idx_in  = RANGE_W'(pick_idx);
               res_stat_in = ST_OK;
               state_in    = S_DONE;
            end else begin
               tbl_we = 1'b1;
               tbl_wa = TA_W'(lvl_next) * TA_W'(MAX_ITEMS) + TA_W'(pos_a_ff);
               tbl_wd = pick_idx;
               // next span still inside the set?
               if (WW'(pos_b_ff) + (WW'(1) << rdlvl_ff) < WW'(cnt_ff)) begin
                  pos_a_in = pos_a_ff + 1'b1;
                  pos_b_in = pos_b_ff + 1'b1;
                  state_in = S_TRD;
               end else begin
                  rdlvl_in = LVL_W'(lvl_next);
                  state_in = S_LVL;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      is_query_ff <= is_query_in;
      rdlvl_ff    <= rdlvl_in;
      pos_a_ff    <= pos_a_in;
      pos_b_ff    <= pos_b_in;
      q_left_ff   <= q_left_in;
      q_right_ff  <= q_right_in;
      res_val_ff  <= res_val_in;
      res_idx_ff  <= res_idx_in;
      res_stat_ff <= res_stat_in;
      if (state_ff == S_DONE && out_free) begin
         rsp_val_ff  <= res_val_ff;
         rsp_idx_ff  <= res_idx_ff;
         rsp_stat_ff <= res_stat_ff;
         rsp_cnt_ff  <= COUNT_W'(cnt_ff);
      end
   end

   // value store
   always_ff @(posedge clock) begin
      if (val_we) begin
         value_mem[val_wa] <= val_wd;
      end
      if (val_rd_en) begin
         val_a_ff <= value_mem[tbl_a_ff];
         val_b_ff <= value_mem[tbl_b_ff];
      end
   end

   // span minimum table
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_wa] <= tbl_wd;
      end
      if (tbl_rd_en) begin
         tbl_a_ff <= tbl_mem[tbl_ra];
         tbl_b_ff <= tbl_mem[tbl_rb];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_min_value  = rsp_val_ff;
   assign rsp_min_index  = rsp_idx_ff;
   assign rsp_status     = rsp_stat_ff;
   assign rsp_item_count = rsp_cnt_ff;

   // a built table always covers at least one value
   a_ready_nonempty: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> cnt_ff != '0)
      else $error("table marked built over an empty set");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_ITEMS))
      else $error("value count beyond capacity");

   // the two span starts are ordered and lie inside the set
   a_span_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TRD |-> pos_a_ff <= pos_b_ff && WW'(pos_b_ff) < WW'(cnt_ff))
      else $error("span start positions out of order or out of range");

   // a query answer lies inside the queried range
   a_pick_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP && is_query_ff |->
         WW'(pick_idx) >= WW'(q_left_ff) && WW'(pick_idx) <= WW'(q_right_ff))
      else $error("query minimum index outside the range");

endmodule

// ===== dv/tb_sparse_table_range_min_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_table_range_min_core: testbench for the sparse table RMQ core
// Drives load and query items with bursty valid and a stalling receiver.
// Each accepted item is predicted by a scoreboard that keeps its own copy of
// the data set, and each result is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_sparse_table_range_min_core;
   import strm_pkg::*;

   localparam int DEPTH      = MAX_ITEMS_DEF;
   localparam int ITEM_GOAL  = 1950;

   typedef struct {
      logic signed [SAMPLE_W-1:0] value;
      logic        [RANGE_W-1:0]  index;
      status_type                 status;
      logic        [COUNT_W-1:0]  count;
   } min_result_type;

   class range_min_scoreboard;
      logic signed [SAMPLE_W-1:0] values [DEPTH];
      int unsigned                set_size;
      bit                         table_built;
      min_result_type             pending [$];
      int unsigned                errors;

      function new();
         set_size    = 0;
         table_built = 0;
         errors      = 0;
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      // predict the result of one accepted item, if it has one
      function void note_request(logic mode, logic signed [SAMPLE_W-1:0] sample,
                                 logic last, logic [RANGE_W-1:0] left,
                                 logic [RANGE_W-1:0] right);
         min_result_type res;
         bit             dropped;
         int             best;
         res.value  = '0;
         res.index  = '0;
         res.status = ST_OK;
         if (mode == MODE_LOAD) begin
            dropped = 0;
            // first load after a build opens a new set
            if (table_built) begin
               set_size    = 0;
               table_built = 0;
            end
            if (set_size < DEPTH) begin
               values[set_size] = sample;
               set_size++;
            end else begin
               dropped = 1;
            end
            // build runs even when the last load was dropped
            if (last)
               table_built = 1;
            if (!dropped && !last)
               return;
            res.status = dropped ? ST_OVERFLOW : ST_BUILT;
         end else if (!table_built || set_size == 0 || left > right ||
                      right >= set_size) begin
            res.status = ST_REJECT;
         end else begin
            // strict less-than keeps the lowest index on ties
            best = int'(left);
            for (int i = int'(left) + 1; i <= int'(right); i++)
               if (values[i] < values[best])
                  best = i;
            res.value  = values[best];
            res.index  = RANGE_W'(best);
            res.status = ST_OK;
         end
         res.count = COUNT_W'(set_size);
         pending.push_back(res);
      endfunction

      task check_response(logic signed [SAMPLE_W-1:0] value, logic [RANGE_W-1:0] index,
                          logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] count);
         min_result_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result status %0d count %0d", status, count));
            return;
         end
         want = pending.pop_front();
         if (status !== want.status)
            report($sformatf("status %0d, want %0d", status, want.status));
         if (value !== want.value)
            report($sformatf("min_value %0d, want %0d", value, want.value));
         if (index !== want.index)
            report($sformatf("min_index %0d, want %0d", index, want.index));
         if (count !== want.count)
            report($sformatf("item_count %0d, want %0d", count, want.count));
      endtask
   endclass

   // receiver behavior, picked anew whenever its random hold count runs out
   typedef enum {RX_OPEN, RX_COIN, RX_SLOW, RX_TICK} rx_style_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_mode = MODE_LOAD;
   logic signed [SAMPLE_W-1:0]  req_sample_value = '0;
   logic                        req_last_sample = 1'b0;
   logic        [RANGE_W-1:0]   req_range_left = '0;
   logic        [RANGE_W-1:0]   req_range_right = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0]  rsp_min_value;
   logic        [RANGE_W-1:0]   rsp_min_index;
   logic        [STATUS_W-1:0]  rsp_status;
   logic        [COUNT_W-1:0]   rsp_item_count;

   range_min_scoreboard sb;
   int           burst_left = 0;
   int           items_sent = 0;
   rx_style_type rx_style = RX_OPEN;
   int unsigned  rx_hold = 0;

   sparse_table_range_min_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_sample_value (req_sample_value),
      .req_last_sample  (req_last_sample),
      .req_range_left   (req_range_left),
      .req_range_right  (req_range_right),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_min_value    (rsp_min_value),
      .rsp_min_index    (rsp_min_index),
      .rsp_status       (rsp_status),
      .rsp_item_count   (rsp_item_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop; the slowest legal run is a small fraction of this
   initial begin
      #2_000_000;
      $display("tb_sparse_table_range_min_core: errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // result side: check every accepted result, then pick next ready value.
   // Styles: fully open, coin flip, mostly stalled, alternating.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_min_value, rsp_min_index, rsp_status, rsp_item_count);
         if (rx_hold == 0) begin
            rx_style = rx_style_type'($urandom_range(0, 3));
            rx_hold  = $urandom_range(8, 64);
         end else begin
            rx_hold--;
         end
         case (rx_style)
            RX_OPEN: rsp_ready <= 1'b1;
            RX_COIN: rsp_ready <= ($urandom_range(0, 1) == 0);
            RX_SLOW: rsp_ready <= ($urandom_range(0, 7) == 0);
            default: rsp_ready <= rx_hold[0];
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // request side. Items go out in bursts; between bursts valid drops for a
   // random gap. Long bursts give stretches with no idling at all.
   // ------------------------------------------------------------------------
   task automatic send_item(logic mode, logic signed [SAMPLE_W-1:0] sample, logic last,
                            logic [RANGE_W-1:0] left, logic [RANGE_W-1:0] right);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 10);
         gap = $urandom_range(0, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_sample_value <= sample;
      req_last_sample  <= last;
      req_range_left   <= left;
      req_range_right  <= right;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(mode, sample, last, left, right);
      burst_left--;
      items_sent++;
   endtask

   // unused fields carry random junk so the core must ignore them
   task automatic load_sample(logic signed [SAMPLE_W-1:0] sample, logic last);
      send_item(MODE_LOAD, sample, last, RANGE_W'($urandom), RANGE_W'($urandom));
   endtask

   task automatic query_range(int unsigned left, int unsigned right);
      send_item(MODE_QUERY, SAMPLE_W'($urandom), 1'($urandom),
                RANGE_W'(left), RANGE_W'(right));
   endtask

   // extremes, a narrow band (lots of ties) or anything
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      logic signed [SAMPLE_W-1:0] s;
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 3))
               0: s = 32'sh7fffffff;
               1: s = 32'sh80000000;
               2: s = '0;
               default: s = -32'sd1;
            endcase
         end
         1, 2: begin
            s = SAMPLE_W'($urandom_range(0, 7));
            s = s - 32'sd4;
         end
         default: s = SAMPLE_W'($urandom);
      endcase
      return s;
   endfunction

   // mostly in-range queries, some out past the set, some reversed
   task automatic random_query(int unsigned n);
      int unsigned l, r;
      case ($urandom_range(0, 9))
         0: begin
            l = $urandom_range(0, 1023);
            r = $urandom_range(0, 1023);
         end
         1: begin
            if (n < DEPTH) begin
               r = $urandom_range(n, 1023);
               l = $urandom_range(0, r);
            end else begin
               l = $urandom_range(0, 1023);
               r = $urandom_range(0, 1023);
            end
         end
         2: begin
            l = $urandom_range(1, 1023);
            r = $urandom_range(0, l - 1);
         end
         default: begin
            l = $urandom_range(0, n - 1);
            r = $urandom_range(l, n - 1);
         end
      endcase
      query_range(l, r);
   endtask

   // one data set, with the odd stray query while it is still open
   task automatic load_set(int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(0, 15) == 0)
            random_query(n);
         load_sample(pick_sample(), i == n - 1);
      end
   endtask

   initial begin
      int unsigned n;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      query_range(0, 0);                   // nothing built yet
      query_range(1023, 1023);
      load_sample(32'sh7fffffff, 1'b0);
      load_sample(32'sh80000000, 1'b0);
      load_sample(32'sd0, 1'b0);
      load_sample(-32'sd1, 1'b0);
      query_range(0, 3);                   // set still open
      load_sample(32'sh80000000, 1'b0);    // ties with index 1
      load_sample(32'sd5, 1'b1);           // build, six values
      query_range(0, 5);
      query_range(2, 5);
      query_range(1, 4);                   // tie, lower index wins
      query_range(0, 3);                   // span exactly a power of two
      query_range(0, 4);
      query_range(5, 5);
      query_range(3, 2);                   // reversed
      query_range(0, 6);                   // past the end of the set
      query_range(0, 1023);
      query_range(1023, 0);
      load_sample(pick_sample(), 1'b1);    // one-value set
      query_range(0, 0);
      query_range(1, 1);

      // --- full set, then loads past capacity ---
      for (int i = 0; i < DEPTH; i++)
         load_sample(pick_sample(), 1'b0);
      query_range(0, 1023);                // full but not built
      load_sample(pick_sample(), 1'b0);    // dropped
      load_sample(pick_sample(), 1'b1);    // dropped, table still built
      query_range(0, 1023);
      query_range(1023, 1023);
      query_range(0, 0);
      query_range(512, 1023);
      repeat (60) random_query(DEPTH);

      // --- random sets, mostly small, a few larger ---
      while (items_sent < ITEM_GOAL) begin
         case ($urandom_range(0, 19))
            0:       n = $urandom_range(65, 200);
            1, 2, 3: n = $urandom_range(17, 64);
            default: n = $urandom_range(1, 16);
         endcase
         load_set(n);
         repeat ($urandom_range(3, 20)) random_query(n);
      end

      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0)
         $display("tb_sparse_table_range_min_core: clean");
      else
         $display("tb_sparse_table_range_min_core: errors");
      $finish;
   end

endmodule
